### rtl/pdc_pkg.sv
package pdc_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int COORD_W       = $clog2(MAX_DIMENSION);
    localparam int DIM_W         = COORD_W + 1;
    localparam int CHAN_W        = 8;
    localparam int COUNT_W       = 25;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = DIM_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [CHAN_W-1:0]  CHAN_FULL   = 8'd255;
    localparam logic [CHAN_W-1:0]  ALPHA_MATCH = 8'd128;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE_LEVEL = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXACT_MODE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAKE_DIFF_IMAGE = 3'd4;

    typedef struct packed {
        logic [CHAN_W-1:0] base_red;
        logic [CHAN_W-1:0] base_green;
        logic [CHAN_W-1:0] base_blue;
        logic [CHAN_W-1:0] base_alpha;
        logic [CHAN_W-1:0] cur_red;
        logic [CHAN_W-1:0] cur_green;
        logic [CHAN_W-1:0] cur_blue;
        logic [CHAN_W-1:0] cur_alpha;
    } pixel_pair_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } diff_pixel_t;

    typedef struct packed {
        logic               frame_done;
        logic [COUNT_W-1:0] mismatch_count;
        logic [COORD_W-1:0] box_min_x;
        logic [COORD_W-1:0] box_min_y;
        logic [COORD_W-1:0] box_max_x;
        logic [COORD_W-1:0] box_max_y;
        logic               frames_match;
    } frame_summary_t;

    typedef struct packed {
        diff_pixel_t    pixel;
        frame_summary_t summary;
    } result_t;

    // geometry held as last index (clamped size minus one)
    typedef struct packed {
        logic [COORD_W-1:0] last_col;
        logic [COORD_W-1:0] last_line;
        logic [CHAN_W-1:0]  tolerance;
        logic               diff_en;
    } cfg_t;

endpackage

### rtl/pdc_if.sv
interface pdc_pixel_if
    import pdc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] base_red;
    logic [CHAN_W-1:0] base_green;
    logic [CHAN_W-1:0] base_blue;
    logic [CHAN_W-1:0] base_alpha;
    logic [CHAN_W-1:0] cur_red;
    logic [CHAN_W-1:0] cur_green;
    logic [CHAN_W-1:0] cur_blue;
    logic [CHAN_W-1:0] cur_alpha;

    modport source (
        output valid, base_red, base_green, base_blue, base_alpha,
        output cur_red, cur_green, cur_blue, cur_alpha,
        input  ready
    );
    modport sink (
        input  valid, base_red, base_green, base_blue, base_alpha,
        input  cur_red, cur_green, cur_blue, cur_alpha,
        output ready
    );
endinterface

interface pdc_result_if
    import pdc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  diff_red;
    logic [CHAN_W-1:0]  diff_green;
    logic [CHAN_W-1:0]  diff_blue;
    logic [CHAN_W-1:0]  diff_alpha;
    logic               frame_done;
    logic [COUNT_W-1:0] mismatch_count;
    logic [COORD_W-1:0] box_min_x;
    logic [COORD_W-1:0] box_min_y;
    logic [COORD_W-1:0] box_max_x;
    logic [COORD_W-1:0] box_max_y;
    logic               frames_match;

    modport source (
        output valid, diff_red, diff_green, diff_blue, diff_alpha,
        output frame_done, mismatch_count, box_min_x, box_min_y,
        output box_max_x, box_max_y, frames_match,
        input  ready
    );
    modport sink (
        input  valid, diff_red, diff_green, diff_blue, diff_alpha,
        input  frame_done, mismatch_count, box_min_x, box_min_y,
        input  box_max_x, box_max_y, frames_match,
        output ready
    );
endinterface

interface pdc_cfg_if
    import pdc_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### rtl/pdc_cfg_regs.sv
module pdc_cfg_regs
    import pdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pdc_cfg_if.sink   cfg,
    output cfg_t      settings
);

    logic [COORD_W-1:0] last_col_reg;
    logic [COORD_W-1:0] last_line_reg;
    logic [CHAN_W-1:0]  tol_level_reg;
    logic               exact_reg;
    logic               diff_en_reg;
    logic               wr_en;

    // 0 acts as 1, above MAX_DIMENSION acts as MAX_DIMENSION
    function automatic logic [COORD_W-1:0] dim_last_idx(input logic [CFG_DATA_W-1:0] v);
        logic [CFG_DATA_W-1:0] m1;
        begin
            m1 = v - CFG_DATA_W'(1);
            if (v == '0)
                dim_last_idx = '0;
            else if (v > CFG_DATA_W'(MAX_DIMENSION))
                dim_last_idx = COORD_W'(MAX_DIMENSION - 1);
            else
                dim_last_idx = m1[COORD_W-1:0];
        end
    endfunction

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid & cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg  <= '0;
            last_line_reg <= '0;
            tol_level_reg <= '0;
            exact_reg     <= 1'b0;
            diff_en_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            case (cfg.index)
                CFG_FRAME_WIDTH:     last_col_reg  <= dim_last_idx(cfg.data);
                CFG_FRAME_HEIGHT:    last_line_reg <= dim_last_idx(cfg.data);
                CFG_TOLERANCE_LEVEL: tol_level_reg <= cfg.data[CHAN_W-1:0];
                CFG_EXACT_MODE:      exact_reg     <= cfg.data[0];
                CFG_MAKE_DIFF_IMAGE: diff_en_reg   <= cfg.data[0];
                default: ;
            endcase
        end
    end

    assign settings.last_col  = last_col_reg;
    assign settings.last_line = last_line_reg;
    assign settings.tolerance = exact_reg ? '0 : tol_level_reg;
    assign settings.diff_en   = diff_en_reg;

endmodule

### rtl/pdc_pixel_eval.sv
module pdc_pixel_eval
    import pdc_pkg::*;
(
    input  pixel_pair_t pair,
    input  cfg_t        settings,
    output logic        match,
    output diff_pixel_t pixel
);

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        begin
            abs_diff = (a > b) ? (a - b) : (b - a);
        end
    endfunction

    logic [3:0] chan_ok;

    always_comb
    begin
        chan_ok[0] = abs_diff(pair.base_red,   pair.cur_red)   <= settings.tolerance;
        chan_ok[1] = abs_diff(pair.base_green, pair.cur_green) <= settings.tolerance;
        chan_ok[2] = abs_diff(pair.base_blue,  pair.cur_blue)  <= settings.tolerance;
        chan_ok[3] = abs_diff(pair.base_alpha, pair.cur_alpha) <= settings.tolerance;
        match = &chan_ok;

        if (!settings.diff_en)
            pixel = '0;
        else if (!match)
        begin
            pixel.red   = CHAN_FULL;
            pixel.green = '0;
            pixel.blue  = '0;
            pixel.alpha = CHAN_FULL;
        end
        else
        begin
            pixel.red   = pair.base_red   >> 1;
            pixel.green = pair.base_green >> 1;
            pixel.blue  = pair.base_blue  >> 1;
            pixel.alpha = ALPHA_MATCH;
        end
    end

endmodule

### rtl/pdc_frame_stats.sv
module pdc_frame_stats
    import pdc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           mismatch,
    input  cfg_t           settings,
    output frame_summary_t summary
);

    logic [COORD_W-1:0] col_reg,       col_next;
    logic [COORD_W-1:0] line_reg,      line_next;
    logic [COUNT_W-1:0] total_reg,     total_next;
    logic [COORD_W-1:0] min_x_reg,     min_x_next;
    logic [COORD_W-1:0] min_y_reg,     min_y_next;
    logic [COORD_W-1:0] max_x_reg,     max_x_next;
    logic [COORD_W-1:0] max_y_reg,     max_y_next;
    logic [COUNT_W-1:0] total_upd;
    logic [COORD_W-1:0] min_x_upd, min_y_upd, max_x_upd, max_y_upd;
    logic               last_col;
    logic               last_pix;
    logic               any;

    always_comb
    begin
        total_upd = total_reg;
        min_x_upd = min_x_reg;
        min_y_upd = min_y_reg;
        max_x_upd = max_x_reg;
        max_y_upd = max_y_reg;
        if (mismatch)
        begin
            if (total_reg == '0)
            begin
                min_x_upd = col_reg;
                min_y_upd = line_reg;
                max_x_upd = col_reg;
                max_y_upd = line_reg;
            end
            else
            begin
                if (col_reg  < min_x_reg) min_x_upd = col_reg;
                if (line_reg < min_y_reg) min_y_upd = line_reg;
                if (col_reg  > max_x_reg) max_x_upd = col_reg;
                if (line_reg > max_y_reg) max_y_upd = line_reg;
            end
            if (total_reg != COUNT_MAX)
                total_upd = total_reg + COUNT_W'(1);
        end

        last_col = col_reg >= settings.last_col;
        last_pix = last_col && (line_reg >= settings.last_line);
        any      = total_upd != '0;

        summary = '0;
        if (last_pix)
        begin
            summary.frame_done     = 1'b1;
            summary.mismatch_count = total_upd;
            summary.box_min_x      = any ? min_x_upd : '0;
            summary.box_min_y      = any ? min_y_upd : '0;
            summary.box_max_x      = any ? max_x_upd : '0;
            summary.box_max_y      = any ? max_y_upd : '0;
            summary.frames_match   = !any;
        end

        if (last_pix)
        begin
            col_next   = '0;
            line_next  = '0;
            total_next = '0;
            min_x_next = '0;
            min_y_next = '0;
            max_x_next = '0;
            max_y_next = '0;
        end
        else
        begin
            col_next   = last_col ? '0 : col_reg + COORD_W'(1);
            line_next  = last_col ? line_reg + COORD_W'(1) : line_reg;
            total_next = total_upd;
            min_x_next = min_x_upd;
            min_y_next = min_y_upd;
            max_x_next = max_x_upd;
            max_y_next = max_y_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            line_reg  <= '0;
            total_reg <= '0;
            min_x_reg <= '0;
            min_y_reg <= '0;
            max_x_reg <= '0;
            max_y_reg <= '0;
        end
        else if (advance)
        begin
            col_reg   <= col_next;
            line_reg  <= line_next;
            total_reg <= total_next;
            min_x_reg <= min_x_next;
            min_y_reg <= min_y_next;
            max_x_reg <= max_x_next;
            max_y_reg <= max_y_next;
        end
    end

endmodule

### rtl/pixel_diff_compare_core.sv
// Throughput: 1 pixel word per cycle unless result.ready stalls the
// output; input register feeds compare and frame statistics, whose
// result lands in the output register, which drives the result word.
// Reset: clears both stages, the frame counters and the config registers
// (width 1, height 1, tolerance 0, exact and diff image off).
module pixel_diff_compare_core
    import pdc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    pdc_pixel_if.sink     pixel,
    pdc_result_if.source  result,
    pdc_cfg_if.sink       cfg
);

    cfg_t           settings;
    logic           s1_valid_reg;
    pixel_pair_t    s1_pair_reg;
    logic           out_valid_reg;
    result_t        out_word_reg;
    logic           s1_ready;
    logic           out_ready;
    logic           advance;
    logic           match;
    diff_pixel_t    diff_pix;
    frame_summary_t summary;

    pdc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    pdc_pixel_eval u_pixel_eval (
        .pair     (s1_pair_reg),
        .settings (settings),
        .match    (match),
        .pixel    (diff_pix)
    );

    pdc_frame_stats u_frame_stats (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .mismatch (!match),
        .settings (settings),
        .summary  (summary)
    );

    assign out_ready   = !out_valid_reg || result.ready;
    assign advance     = s1_valid_reg && out_ready;
    assign s1_ready    = !s1_valid_reg || out_ready;
    assign pixel.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= pixel.valid;
            if (out_ready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && pixel.valid)
        begin
            s1_pair_reg.base_red   <= pixel.base_red;
            s1_pair_reg.base_green <= pixel.base_green;
            s1_pair_reg.base_blue  <= pixel.base_blue;
            s1_pair_reg.base_alpha <= pixel.base_alpha;
            s1_pair_reg.cur_red    <= pixel.cur_red;
            s1_pair_reg.cur_green  <= pixel.cur_green;
            s1_pair_reg.cur_blue   <= pixel.cur_blue;
            s1_pair_reg.cur_alpha  <= pixel.cur_alpha;
        end
        if (advance)
        begin
            out_word_reg.pixel   <= diff_pix;
            out_word_reg.summary <= summary;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.diff_red       = out_word_reg.pixel.red;
    assign result.diff_green     = out_word_reg.pixel.green;
    assign result.diff_blue      = out_word_reg.pixel.blue;
    assign result.diff_alpha     = out_word_reg.pixel.alpha;
    assign result.frame_done     = out_word_reg.summary.frame_done;
    assign result.mismatch_count = out_word_reg.summary.mismatch_count;
    assign result.box_min_x      = out_word_reg.summary.box_min_x;
    assign result.box_min_y      = out_word_reg.summary.box_min_y;
    assign result.box_max_x      = out_word_reg.summary.box_max_x;
    assign result.box_max_y      = out_word_reg.summary.box_max_y;
    assign result.frames_match   = out_word_reg.summary.frames_match;

    a_match_summary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result.frames_match |->
            result.frame_done && result.mismatch_count == '0)
        else $error("frames_match with nonzero count or outside frame end");

    a_idle_summary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.frame_done |->
            result.mismatch_count == '0 && !result.frames_match)
        else $error("summary fields set on a non-final word");

    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result.frame_done && !result.frames_match |->
            result.box_min_x <= result.box_max_x && result.box_min_y <= result.box_max_y)
        else $error("bounding box inverted");

    a_diff_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> result.diff_alpha == '0 || result.diff_alpha == ALPHA_MATCH ||
            result.diff_alpha == CHAN_FULL)
        else $error("diff alpha outside its code set");

endmodule

### tb/pixel_diff_compare_core_tb.sv
module pixel_diff_compare_core_tb;
    import pdc_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int SHOW_LIMIT  = 10;

    typedef struct {
        logic [CFG_INDEX_W-1:0] idx;
        int unsigned            val;
    } reg_write_t;

    logic clk = 1'b0;
    logic rst_n;

    pdc_pixel_if  pixel_bus ();
    pdc_result_if result_bus ();
    pdc_cfg_if    cfg_bus ();

    pixel_diff_compare_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always #5 clk = ~clk;

    // shadow registers
    logic [DIM_W-1:0]  reg_width  = 1;
    logic [DIM_W-1:0]  reg_height = 1;
    logic [CHAN_W-1:0] reg_tol    = 0;
    logic              reg_exact  = 0;
    logic              reg_diff   = 0;

    // frame statistics
    int unsigned col_pos, line_pos, miss_total;
    int unsigned box_left, box_top, box_right, box_bottom;

    pixel_pair_t pairs_waiting[$];
    result_t     diff_words_due[$];
    reg_write_t  reg_plan[$];

    bit pair_taken;
    bit steady_flow;
    bit sink_hold_req;
    bit hold_served;
    int hold_left;

    int unsigned cycle_count;
    int unsigned fault_count;
    int unsigned words_checked;
    int unsigned frames_checked;
    int unsigned frames_with_miss;

    function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIMENSION)
            return MAX_DIMENSION;
        return v;
    endfunction

    function automatic void restart_frame();
        col_pos    = 0;
        line_pos   = 0;
        miss_total = 0;
        box_left   = eff_dim(reg_width);
        box_top    = eff_dim(reg_height);
        box_right  = 0;
        box_bottom = 0;
    endfunction

    function automatic bit chan_off(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b, int tol);
        int da, db;
        da = a;
        db = b;
        return ((da > db) ? da - db : db - da) > tol;
    endfunction

    function automatic result_t grade_pixel(pixel_pair_t p);
        int unsigned w, h, x, y;
        int tol;
        bit miss, last_col;
        result_t r;
        w   = eff_dim(reg_width);
        h   = eff_dim(reg_height);
        tol = reg_exact ? 0 : int'(reg_tol);
        x   = col_pos;
        y   = line_pos;
        r   = '0;
        miss = chan_off(p.base_red, p.cur_red, tol) || chan_off(p.base_green, p.cur_green, tol)
            || chan_off(p.base_blue, p.cur_blue, tol)
            || chan_off(p.base_alpha, p.cur_alpha, tol);
        if (miss)
        begin
            if (miss_total == 0)
            begin
                box_left   = x;
                box_top    = y;
                box_right  = x;
                box_bottom = y;
            end
            else
            begin
                if (x < box_left)   box_left   = x;
                if (y < box_top)    box_top    = y;
                if (x > box_right)  box_right  = x;
                if (y > box_bottom) box_bottom = y;
            end
            if (miss_total < COUNT_MAX)
                miss_total++;
        end
        if (reg_diff)
        begin
            if (miss)
            begin
                r.pixel.red   = CHAN_FULL;
                r.pixel.alpha = CHAN_FULL;
            end
            else
            begin
                r.pixel.red   = p.base_red >> 1;
                r.pixel.green = p.base_green >> 1;
                r.pixel.blue  = p.base_blue >> 1;
                r.pixel.alpha = ALPHA_MATCH;
            end
        end
        last_col = (x >= w - 1);
        if (last_col && y >= h - 1)
        begin
            r.summary.frame_done     = 1'b1;
            r.summary.mismatch_count = COUNT_W'(miss_total);
            if (miss_total != 0)
            begin
                r.summary.box_min_x = COORD_W'(box_left);
                r.summary.box_min_y = COORD_W'(box_top);
                r.summary.box_max_x = COORD_W'(box_right);
                r.summary.box_max_y = COORD_W'(box_bottom);
            end
            else
                r.summary.frames_match = 1'b1;
            restart_frame();
        end
        else if (last_col)
        begin
            col_pos  = 0;
            line_pos = y + 1;
        end
        else
            col_pos = x + 1;
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] rand_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    // current channel value inside or beyond the tolerance, boundaries favored
    function automatic logic [CHAN_W-1:0] pick_chan(logic [CHAN_W-1:0] base, int tol, bit outside);
        int b, lo, hi;
        b = base;
        if (outside)
        begin
            if (b >= tol + 1 && (b + tol + 1 > 255 || $urandom_range(1) == 1))
            begin
                hi = b - tol - 1;
                return ($urandom_range(2) == 0) ? CHAN_W'(hi) : CHAN_W'($urandom_range(hi, 0));
            end
            if (b + tol + 1 <= 255)
            begin
                lo = b + tol + 1;
                return ($urandom_range(2) == 0) ? CHAN_W'(lo) : CHAN_W'($urandom_range(255, lo));
            end
        end
        lo = (b > tol) ? b - tol : 0;
        hi = (b + tol < 255) ? b + tol : 255;
        case ($urandom_range(3))
            0: return CHAN_W'(lo);
            1: return CHAN_W'(hi);
            default: return CHAN_W'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic pixel_pair_t make_pair(int miss_pct, bit force_miss);
        pixel_pair_t p;
        int tol, ch;
        bit miss;
        tol  = reg_exact ? 0 : int'(reg_tol);
        miss = force_miss || ($urandom_range(99) < miss_pct);
        ch   = $urandom_range(3);
        p.base_red   = rand_byte();
        p.base_green = rand_byte();
        p.base_blue  = rand_byte();
        p.base_alpha = rand_byte();
        p.cur_red   = pick_chan(p.base_red, tol, miss && (ch == 0 || $urandom_range(3) == 0));
        p.cur_green = pick_chan(p.base_green, tol, miss && (ch == 1 || $urandom_range(3) == 0));
        p.cur_blue  = pick_chan(p.base_blue, tol, miss && (ch == 2 || $urandom_range(3) == 0));
        p.cur_alpha = pick_chan(p.base_alpha, tol, miss && (ch == 3 || $urandom_range(3) == 0));
        return p;
    endfunction

    function automatic string show(result_t r);
        return $sformatf("rgba=%0d,%0d,%0d,%0d done=%0b cnt=%0d box=(%0d,%0d)-(%0d,%0d) match=%0b",
            r.pixel.red, r.pixel.green, r.pixel.blue, r.pixel.alpha, r.summary.frame_done,
            r.summary.mismatch_count, r.summary.box_min_x, r.summary.box_min_y,
            r.summary.box_max_x, r.summary.box_max_y, r.summary.frames_match);
    endfunction

    task automatic program_regs();
        reg_write_t wr;
        while (reg_plan.size() != 0)
        begin
            wr = reg_plan.pop_front();
            @(negedge clk);
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= wr.idx;
            cfg_bus.data  <= wr.val[CFG_DATA_W-1:0];
            @(posedge clk);
            while (!cfg_bus.ready)
                @(posedge clk);
            case (wr.idx)
                CFG_FRAME_WIDTH:     reg_width  = wr.val[DIM_W-1:0];
                CFG_FRAME_HEIGHT:    reg_height = wr.val[DIM_W-1:0];
                CFG_TOLERANCE_LEVEL: reg_tol    = wr.val[CHAN_W-1:0];
                CFG_EXACT_MODE:      reg_exact  = wr.val[0];
                CFG_MAKE_DIFF_IMAGE: reg_diff   = wr.val[0];
                default: ;
            endcase
        end
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_random(int count, int miss_pct, bit bookend_miss);
        for (int i = 0; i < count; i++)
            pairs_waiting.push_back(make_pair(miss_pct, bookend_miss && (i == 0 || i == count - 1)));
    endtask

    task automatic settle();
        @(negedge clk);
        while (pairs_waiting.size() != 0 || pixel_bus.valid || diff_words_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // pixel driver
    always @(negedge clk)
    begin
        pixel_pair_t nxt;
        if (!rst_n)
            pixel_bus.valid <= 1'b0;
        else if (!pixel_bus.valid || pair_taken)
        begin
            if (pairs_waiting.size() != 0 && (steady_flow || $urandom_range(99) >= 22))
            begin
                nxt = pairs_waiting[0];
                pixel_bus.valid      <= 1'b1;
                pixel_bus.base_red   <= nxt.base_red;
                pixel_bus.base_green <= nxt.base_green;
                pixel_bus.base_blue  <= nxt.base_blue;
                pixel_bus.base_alpha <= nxt.base_alpha;
                pixel_bus.cur_red    <= nxt.cur_red;
                pixel_bus.cur_green  <= nxt.cur_green;
                pixel_bus.cur_blue   <= nxt.cur_blue;
                pixel_bus.cur_alpha  <= nxt.cur_alpha;
            end
            else
                pixel_bus.valid <= 1'b0;
        end
    end

    // accepted pixel words feed the predictor
    always @(posedge clk)
    begin
        pair_taken = 1'b0;
        if (rst_n && pixel_bus.valid && pixel_bus.ready)
        begin
            pair_taken = 1'b1;
            diff_words_due.push_back(grade_pixel(pairs_waiting.pop_front()));
        end
    end

    // result ready, with one long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            result_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (sink_hold_req && !hold_served)
        begin
            result_bus.ready <= 1'b0;
            hold_left <= 80;
            hold_served <= 1'b1;
        end
        else
            result_bus.ready <= steady_flow || ($urandom_range(99) >= 22);
    end

    // result monitor
    always @(posedge clk)
    begin
        result_t seen, want;
        bit bad;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            seen.pixel.red              = result_bus.diff_red;
            seen.pixel.green            = result_bus.diff_green;
            seen.pixel.blue             = result_bus.diff_blue;
            seen.pixel.alpha            = result_bus.diff_alpha;
            seen.summary.frame_done     = result_bus.frame_done;
            seen.summary.mismatch_count = result_bus.mismatch_count;
            seen.summary.box_min_x      = result_bus.box_min_x;
            seen.summary.box_min_y      = result_bus.box_min_y;
            seen.summary.box_max_x      = result_bus.box_max_x;
            seen.summary.box_max_y      = result_bus.box_max_y;
            seen.summary.frames_match   = result_bus.frames_match;
            if (diff_words_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= SHOW_LIMIT)
                    $display("cycle %0d: unexpected word %s", cycle_count, show(seen));
            end
            else
            begin
                want = diff_words_due.pop_front();
                words_checked++;
                if (want.summary.frame_done)
                begin
                    frames_checked++;
                    if (!want.summary.frames_match)
                        frames_with_miss++;
                end
                bad = seen.pixel.red !== want.pixel.red
                    || seen.pixel.green !== want.pixel.green
                    || seen.pixel.blue !== want.pixel.blue
                    || seen.pixel.alpha !== want.pixel.alpha
                    || seen.summary.frame_done !== want.summary.frame_done
                    || seen.summary.mismatch_count !== want.summary.mismatch_count
                    || seen.summary.box_min_x !== want.summary.box_min_x
                    || seen.summary.box_min_y !== want.summary.box_min_y
                    || seen.summary.box_max_x !== want.summary.box_max_x
                    || seen.summary.box_max_y !== want.summary.box_max_y
                    || seen.summary.frames_match !== want.summary.frames_match;
                if (bad)
                begin
                    fault_count++;
                    if (fault_count <= SHOW_LIMIT)
                        $display("cycle %0d: word %0d\n  exp %s\n  got %s",
                            cycle_count, words_checked, show(want), show(seen));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                cycle_count, diff_words_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned val;
        int miss_pct;
        rst_n             = 1'b0;
        pixel_bus.valid   = 1'b0;
        pixel_bus.base_red   = '0;
        pixel_bus.base_green = '0;
        pixel_bus.base_blue  = '0;
        pixel_bus.base_alpha = '0;
        pixel_bus.cur_red    = '0;
        pixel_bus.cur_green  = '0;
        pixel_bus.cur_blue   = '0;
        pixel_bus.cur_alpha  = '0;
        result_bus.ready  = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = '0;
        cfg_bus.data      = '0;
        restart_frame();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset geometry: every word closes a 1x1 frame, diff image off
        pairs_waiting.push_back(pixel_pair_t'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        pairs_waiting.push_back(pixel_pair_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        pairs_waiting.push_back(pixel_pair_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
        pairs_waiting.push_back(pixel_pair_t'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01});
        settle();

        reg_plan.push_back(reg_write_t'{CFG_FRAME_WIDTH, 3});
        reg_plan.push_back(reg_write_t'{CFG_FRAME_HEIGHT, 2});
        reg_plan.push_back(reg_write_t'{CFG_TOLERANCE_LEVEL, 10});
        reg_plan.push_back(reg_write_t'{CFG_EXACT_MODE, 0});
        reg_plan.push_back(reg_write_t'{CFG_MAKE_DIFF_IMAGE, 1});
        program_regs();
        pairs_waiting.push_back(pixel_pair_t'{8'hFF, 8'h81, 8'h01, 8'h7F, 8'hFF, 8'h81, 8'h01, 8'h7F});
        pairs_waiting.push_back(pixel_pair_t'{8'h20, 8'h20, 8'h20, 8'h20, 8'h2A, 8'h16, 8'h2A, 8'h16});
        pairs_waiting.push_back(pixel_pair_t'{8'h50, 8'h50, 8'h50, 8'h50, 8'h45, 8'h50, 8'h50, 8'h50});
        pairs_waiting.push_back(pixel_pair_t'{8'h50, 8'h50, 8'h50, 8'h50, 8'h50, 8'h5B, 8'h50, 8'h50});
        pairs_waiting.push_back(pixel_pair_t'{8'h50, 8'h50, 8'h50, 8'h50, 8'h50, 8'h50, 8'h45, 8'h50});
        pairs_waiting.push_back(pixel_pair_t'{8'h50, 8'h50, 8'h50, 8'h50, 8'h50, 8'h50, 8'h50, 8'h5B});
        pairs_waiting.push_back(pixel_pair_t'{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h0A, 8'hF5, 8'h0A, 8'hF5});
        pairs_waiting.push_back(pixel_pair_t'{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hF4, 8'h0B, 8'hF4, 8'h0B});
        settle();

        // exact compare overrides the tolerance of 10
        reg_plan.push_back(reg_write_t'{CFG_EXACT_MODE, 1});
        program_regs();
        pairs_waiting.push_back(pixel_pair_t'{8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33});
        pairs_waiting.push_back(pixel_pair_t'{8'h33, 8'h33, 8'h33, 8'h33, 8'h34, 8'h33, 8'h33, 8'h33});
        pairs_waiting.push_back(pixel_pair_t'{8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h32});
        pairs_waiting.push_back(pixel_pair_t'{8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFE});
        settle();

        // zero geometry acts as 1x1
        reg_plan.push_back(reg_write_t'{CFG_FRAME_WIDTH, 0});
        reg_plan.push_back(reg_write_t'{CFG_FRAME_HEIGHT, 0});
        reg_plan.push_back(reg_write_t'{CFG_TOLERANCE_LEVEL, 255});
        reg_plan.push_back(reg_write_t'{CFG_EXACT_MODE, 0});
        program_regs();
        pairs_waiting.push_back(pixel_pair_t'{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        pairs_waiting.push_back(pixel_pair_t'{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF});
        pairs_waiting.push_back(pixel_pair_t'{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF0});
        settle();

        for (int ph = 0; ph < 20; ph++)
        begin
            if ($urandom_range(9) < 6)
            begin
                case ($urandom_range(9))
                    0: val = 0;
                    1: val = MAX_DIMENSION;
                    2: val = 8191;
                    3: val = $urandom_range(40, 9);
                    default: val = $urandom_range(8, 1);
                endcase
                reg_plan.push_back(reg_write_t'{CFG_FRAME_WIDTH, val});
            end
            if ($urandom_range(9) < 6)
            begin
                case ($urandom_range(9))
                    0: val = 0;
                    1: val = MAX_DIMENSION;
                    2: val = $urandom_range(8191, MAX_DIMENSION + 1);
                    default: val = $urandom_range(6, 1);
                endcase
                reg_plan.push_back(reg_write_t'{CFG_FRAME_HEIGHT, val});
            end
            if ($urandom_range(1) == 1)
            begin
                case ($urandom_range(5))
                    0: val = 0;
                    1: val = 255;
                    2, 3: val = $urandom_range(255);
                    default: val = $urandom_range(16, 1);
                endcase
                reg_plan.push_back(reg_write_t'{CFG_TOLERANCE_LEVEL, val});
            end
            if ($urandom_range(1) == 1)
                reg_plan.push_back(reg_write_t'{CFG_EXACT_MODE, ($urandom_range(3) == 0)});
            if ($urandom_range(1) == 1)
                reg_plan.push_back(reg_write_t'{CFG_MAKE_DIFF_IMAGE, ($urandom_range(3) != 0)});
            program_regs();
            steady_flow = (ph == 5);
            if (ph == 11)
                sink_hold_req = 1'b1;
            case ($urandom_range(4))
                0: miss_pct = 0;
                1: miss_pct = 3;
                2: miss_pct = 25;
                3: miss_pct = 60;
                default: miss_pct = 100;
            endcase
            send_random($urandom_range(62, 32), miss_pct, 1'b0);
            settle();
        end
        steady_flow = 1'b0;

        // close any open frame
        reg_plan.push_back(reg_write_t'{CFG_FRAME_WIDTH, 1});
        reg_plan.push_back(reg_write_t'{CFG_FRAME_HEIGHT, 1});
        program_regs();
        send_random(1, 50, 1'b0);
        settle();

        $display("%0d diff words checked, %0d frame summaries (%0d with mismatches)",
            words_checked, frames_checked, frames_with_miss);
        $display("geometry 0..8191 clamped, tolerance 0..255, exact/diff toggled, long sink stall");
        if (fault_count == 0 && diff_words_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
